// ===== src/patched_read_range_splitter_unit_defines.svh =====
// assertion macros for the read range splitter top level
`ifndef PATCHED_READ_RANGE_SPLITTER_UNIT_DEFINES_SVH
`define PATCHED_READ_RANGE_SPLITTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication on clk, off during rst
`define PRRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication on clk, off during rst
`define PRRS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PRRS_ASSERT_NOW(label, ante, cons, msg)
`define PRRS_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== src/prrs_pkg.sv =====
// types and constants of the read range splitter
`timescale 1ns / 1ps
package prrs_pkg;

  // word offset where the replacement area begins
  localparam logic [31:0] SPLIT_WORD = 32'h8000_0000;

  // default table depth
  localparam int MAX_ENTRIES_DEF = 16;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [0:0] REG_ENTRY_COUNT = 1'b0;

  // input item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // segment sources
  localparam logic [1:0] SRC_DISC = 2'd0;
  localparam logic [1:0] SRC_FILE = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [3:0]  entry_index;
    logic [31:0] entry_start;
    logic [31:0] entry_words;
    logic [31:0] read_offset;
    logic [31:0] read_bytes;
  } req_t;

  typedef struct packed {
    logic [1:0]  source;
    logic [3:0]  entry_hit;
    logic [31:0] start_offset;
    logic [31:0] segment_bytes;
    logic        last;
  } seg_t;

  // classified command passed from front to back
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_DISC  = 2'd1,
    CMD_SPLIT = 2'd2,
    CMD_TABLE = 2'd3
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [3:0]  slot;
    logic [31:0] off;   // entry start for load, word offset for reads
    logic [31:0] aux;   // entry words for load, disc segment bytes for reads
    logic [31:0] rest;  // bytes left for the table part
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic walking;
  } bk_status_t;

endpackage

// ===== src/prrs_front.sv =====
// front stage: takes input items and classifies them into commands
`timescale 1ns / 1ps
module prrs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  prrs_pkg::req_t      req,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output prrs_pkg::cmd_t      cmd
);

  logic           cmd_valid_next;
  prrs_pkg::cmd_t class_cmd;
  logic           class_keep;
  logic [31:0]    len_w;
  logic [31:0]    end_word;
  logic [31:0]    off_x4;
  logic           accept;
  logic           push;

  // byte length rounded down to words, last word touched, offset in bytes
  assign len_w    = {req.read_bytes[31:2], 2'b00};
  assign end_word = req.read_offset + {2'b00, req.read_bytes[31:2]} - 32'd1;
  assign off_x4   = {req.read_offset[29:0], 2'b00};

  // classify the item
  always_comb begin
    class_cmd.op   = prrs_pkg::CMD_LOAD;
    class_cmd.slot = req.entry_index;
    class_cmd.off  = req.entry_start;
    class_cmd.aux  = req.entry_words;
    class_cmd.rest = 32'd0;
    class_keep     = 1'b1;
    if (req.kind == prrs_pkg::KIND_READ) begin
      class_cmd.off = req.read_offset;
      if (len_w == 32'd0) begin
        class_keep = 1'b0;
      end else if (!req.read_offset[31]) begin
        if (!end_word[31]) begin
          class_cmd.op  = prrs_pkg::CMD_DISC;
          class_cmd.aux = len_w;
        end else begin
          // head up to the boundary, the rest goes on at the boundary
          class_cmd.op   = prrs_pkg::CMD_SPLIT;
          class_cmd.aux  = 32'd0 - off_x4;
          class_cmd.rest = len_w + off_x4;
        end
      end else begin
        class_cmd.op   = prrs_pkg::CMD_TABLE;
        class_cmd.aux  = 32'd0;
        class_cmd.rest = len_w;
      end
    end
  end

  // handshake
  assign push      = cmd_valid && cmd_ready;
  assign req_stall = cmd_valid && !cmd_ready;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    cmd_valid_next = cmd_valid;
    if (accept) begin
      cmd_valid_next = class_keep;
    end else if (push) begin
      cmd_valid_next = 1'b0;
    end
  end

  // command register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= cmd_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= class_cmd;
    end
  end

endmodule

// ===== src/prrs_queue.sv =====
// short command queue between front and back
`timescale 1ns / 1ps
module prrs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  prrs_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop,
  output prrs_pkg::cmd_t pop_cmd
);

  localparam int DEPTH = prrs_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  prrs_pkg::cmd_t  slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CNTW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNTW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== src/prrs_back.sv =====
// back stage: table store, binary search and segment walk
`timescale 1ns / 1ps
module prrs_back #(
  parameter int MAX_ENTRIES = prrs_pkg::MAX_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [4:0]           entry_count,
  input  logic                 q_valid,
  input  prrs_pkg::cmd_t       q_cmd,
  output logic                 q_pop,
  output logic                 seg_valid,
  input  logic                 seg_stall,
  output prrs_pkg::seg_t       seg,
  output prrs_pkg::bk_status_t status
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SADDR = 6'b000010,
    ST_SEVAL = 6'b000100,
    ST_WADDR = 6'b001000,
    ST_WEVAL = 6'b010000,
    ST_WEMIT = 6'b100000
  } state_t;

  state_t         state, state_next;
  logic [CW-1:0]  lo, lo_next;
  logic [CW-1:0]  span, span_next;
  logic [CW-1:0]  k_r, k_next;
  logic [CW-1:0]  idx, idx_next;
  logic [31:0]    off_r, off_next;
  logic [31:0]    len_r, len_next;
  logic [31:0]    skip_r, skip_next;
  logic [31:0]    raw_r, raw_next;
  logic           seg_valid_next;
  prrs_pkg::seg_t seg_next;

  logic [31:0]    mem_start [MAX_ENTRIES];
  logic [31:0]    mem_words [MAX_ENTRIES];
  logic [31:0]    rd_start;
  logic [31:0]    rd_words;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  wr_addr;
  logic           mem_we;

  logic [CW-1:0]  n_cnt;
  logic [CW-1:0]  k_mid;
  logic [31:0]    e_sum;
  logic           probe_right;
  logic           probe_hit;
  logic [CW-1:0]  span_step;
  logic [32:0]    diff;
  logic [31:0]    seg_bytes;
  logic [31:0]    len_left;
  logic           out_free;
  logic           slot_ok;

  // entries in use, capped at the table depth
  assign n_cnt = ({27'd0, entry_count} > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                           : CW'(entry_count);

  assign out_free = !seg_valid || !seg_stall;
  assign slot_ok  = ({28'd0, q_cmd.slot} < 32'(MAX_ENTRIES));
  assign wr_addr  = AW'(q_cmd.slot);

  // search probe
  assign k_mid       = lo + (span >> 1);
  assign e_sum       = rd_start + rd_words;
  assign probe_right = (off_r > rd_start);
  assign probe_hit   = (rd_start == off_r) || (probe_right && (e_sum > off_r));
  assign span_step   = probe_right ? ((span - CW'(1)) >> 1) : (span >> 1);

  // clip the segment to the bytes left
  assign diff      = {1'b0, len_r} - {1'b0, raw_r};
  assign seg_bytes = diff[32] ? len_r : raw_r;
  assign len_left  = diff[32] ? 32'd0 : diff[31:0];

  assign rd_addr = (state == ST_SADDR) ? AW'(k_mid) : AW'(idx);

  // sequencer
  always_comb begin
    state_next     = state;
    lo_next        = lo;
    span_next      = span;
    k_next         = k_r;
    idx_next       = idx;
    off_next       = off_r;
    len_next       = len_r;
    skip_next      = skip_r;
    raw_next       = raw_r;
    seg_valid_next = seg_valid && seg_stall;
    seg_next       = seg;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          unique case (q_cmd.op)
            prrs_pkg::CMD_LOAD: begin
              mem_we = slot_ok;
            end
            prrs_pkg::CMD_DISC: begin
              seg_valid_next = 1'b1;
              seg_next = '{prrs_pkg::SRC_DISC, 4'd0, q_cmd.off, q_cmd.aux, 1'b1};
            end
            prrs_pkg::CMD_SPLIT: begin
              seg_valid_next = 1'b1;
              seg_next = '{prrs_pkg::SRC_DISC, 4'd0, q_cmd.off, q_cmd.aux,
                           (q_cmd.rest == 32'd0)};
              if (q_cmd.rest != 32'd0) begin
                off_next  = prrs_pkg::SPLIT_WORD;
                len_next  = q_cmd.rest;
                lo_next   = '0;
                span_next = n_cnt;
                idx_next  = n_cnt;
                state_next = (n_cnt == '0) ? ST_WADDR : ST_SADDR;
              end
            end
            prrs_pkg::CMD_TABLE: begin
              off_next  = q_cmd.off;
              len_next  = q_cmd.rest;
              lo_next   = '0;
              span_next = n_cnt;
              idx_next  = n_cnt;
              state_next = (n_cnt == '0) ? ST_WADDR : ST_SADDR;
            end
          endcase
        end
      end
      ST_SADDR: begin
        k_next     = k_mid;
        state_next = ST_SEVAL;
      end
      ST_SEVAL: begin
        if (probe_hit) begin
          idx_next   = k_r;
          state_next = ST_WADDR;
        end else begin
          if (probe_right) begin
            lo_next = k_r + CW'(1);
          end
          span_next = span_step;
          if (span_step == '0) begin
            idx_next   = n_cnt;
            state_next = ST_WADDR;
          end else begin
            state_next = ST_SADDR;
          end
        end
      end
      ST_WADDR: begin
        if (idx >= n_cnt) begin
          // miss or table exhausted
          if (out_free) begin
            seg_valid_next = 1'b1;
            seg_next = '{prrs_pkg::SRC_ZERO, 4'd0, 32'd0, len_r, 1'b1};
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_WEVAL;
        end
      end
      ST_WEVAL: begin
        skip_next  = (off_r - rd_start) << 2;
        raw_next   = (rd_words + rd_start - off_r) << 2;
        state_next = ST_WEMIT;
      end
      ST_WEMIT: begin
        if (out_free) begin
          seg_valid_next = 1'b1;
          seg_next = '{prrs_pkg::SRC_FILE, 4'(idx), skip_r, seg_bytes,
                       (len_left == 32'd0)};
          len_next   = len_left;
          off_next   = off_r + {2'b00, seg_bytes[31:2]};
          idx_next   = idx + CW'(1);
          state_next = (len_left == 32'd0) ? ST_IDLE : ST_WADDR;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seg_valid <= 1'b0;
    end else begin
      state     <= state_next;
      seg_valid <= seg_valid_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    lo     <= lo_next;
    span   <= span_next;
    k_r    <= k_next;
    idx    <= idx_next;
    off_r  <= off_next;
    len_r  <= len_next;
    skip_r <= skip_next;
    raw_r  <= raw_next;
    seg    <= seg_next;
  end

  // range table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_start[wr_addr] <= q_cmd.off;
      mem_words[wr_addr] <= q_cmd.aux;
    end
    rd_start <= mem_start[rd_addr];
    rd_words <= mem_words[rd_addr];
  end

  assign status.busy    = (state != ST_IDLE);
  assign status.walking = (state == ST_WEMIT);

endmodule

// ===== src/patched_read_range_splitter_unit.sv =====
// Read range splitter top level. Items enter through a one-entry classify stage and
// a two-deep command queue, so the input takes a transfer every cycle until the queue
// fills. The back end handles one command at a time; a table load and a disc-only read
// each go straight from the idle state. Reads that reach the replacement area run a
// binary search over the table, each probe split into an address step and an evaluate
// step by the registered read of the table memory, then walk the replacement segments
// with a table read, offset math, and a clip and emit step for each, and close with a
// zero-fill segment where the table runs out. Output stalls hold the back end. The table has no
// reset; entries read before they are loaded give undefined segments.
`timescale 1ns / 1ps
`include "patched_read_range_splitter_unit_defines.svh"
module patched_read_range_splitter_unit #(
  parameter int MAX_ENTRIES = prrs_pkg::MAX_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  prrs_pkg::req_t                req,
  output logic                          seg_valid,
  input  logic                          seg_stall,
  output prrs_pkg::seg_t                seg,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prrs_pkg::PADDR_W-1:0]  paddr,
  input  logic [prrs_pkg::PDATA_W-1:0]  pwdata,
  output logic [prrs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  logic                 entry_count;
  logic [4:0]           entry_count_q;
  logic                 cmd_valid;
  logic                 cmd_ready;
  prrs_pkg::cmd_t       cmd;
  logic                 q_valid;
  logic                 q_pop;
  prrs_pkg::cmd_t       q_cmd;
  prrs_pkg::bk_status_t bk_status;
  logic                 cfg_sel;

  // register decode
  assign pready      = 1'b1;
  assign cfg_sel     = (paddr[prrs_pkg::PADDR_W-1:2] == prrs_pkg::REG_ENTRY_COUNT);
  assign entry_count = psel && penable && pwrite && cfg_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count_q <= 5'd0;
    end else if (entry_count) begin
      entry_count_q <= pwdata[4:0];
    end
  end

  assign prdata = cfg_sel ? {27'd0, entry_count_q} : '0;

  // front: accept and classify
  prrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // command queue
  prrs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cmd_valid),
    .push_ready (cmd_ready),
    .push_cmd   (cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  // back: table, search and segment output
  prrs_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_count (entry_count_q),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .seg_valid   (seg_valid),
    .seg_stall   (seg_stall),
    .seg         (seg),
    .status      (bk_status)
  );

  // checks
  `PRRS_ASSERT_NOW(a_zero_fill_last, seg_valid && seg.source == prrs_pkg::SRC_ZERO, seg.last, "zero fill segment not marked last")
  `PRRS_ASSERT_NOW(a_hit_only_file, seg_valid && seg.source != prrs_pkg::SRC_FILE, seg.entry_hit == 4'd0, "entry hit set on a non-replacement segment")
  `PRRS_ASSERT_NOW(a_file_from_walk, $rose(seg_valid) && seg.source == prrs_pkg::SRC_FILE, $past(bk_status.walking), "replacement segment not from the walk")
  `PRRS_ASSERT_NOW(a_rise_needs_work, $rose(seg_valid), $past(q_valid || bk_status.busy), "segment with no command pending")

endmodule

// ===== sim/patched_read_range_splitter_unit_tb.sv =====
// testbench for the read range splitter: items checked against a segment predictor
`timescale 1ns / 1ps
module patched_read_range_splitter_unit_tb;
  import prrs_pkg::*;

  localparam int TBL_DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;
  localparam int RANDOM_ITEMS = 350;
  localparam int MAX_REPORTS = 40;
  localparam logic [PADDR_W-1:0] ADDR_ENTRY_COUNT = PADDR_W'(REG_ENTRY_COUNT) << 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic seg_valid;
  logic seg_stall = 1'b0;
  seg_t seg;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // shadow of the block's table and register
  logic [31:0] tbl_start [TBL_DEPTH];
  logic [31:0] tbl_words [TBL_DEPTH];
  logic [4:0] entry_count_sh = '0;

  req_t req_backlog [$];
  seg_t pending_segs [$];

  int errors = 0;
  int n_loads = 0;
  int n_reads = 0;
  int n_segs = 0;
  int n_settings = 0;
  int queued_items = 0;
  int cycles = 0;
  bit in_done = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  patched_read_range_splitter_unit #(
    .MAX_ENTRIES(TBL_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .seg_valid(seg_valid),
    .seg_stall(seg_stall),
    .seg(seg),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial forever #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // segment predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned live_entries();
    return (entry_count_sh > TBL_DEPTH) ? TBL_DEPTH : int'(entry_count_sh);
  endfunction

  // binary search: exact start match, or start <= off < end
  function automatic int unsigned search_table(logic [31:0] off);
    int unsigned lo;
    int unsigned span;
    int unsigned k;
    logic [31:0] s;
    logic [31:0] e;
    lo = 0;
    span = live_entries();
    while (span != 0) begin
      k = lo + (span >> 1);
      s = tbl_start[k];
      e = s + tbl_words[k];
      if (s == off) return k;
      if (off > s) begin
        if (e > off) return k;
        lo = k + 1;
        span--;
      end
      span >>= 1;
    end
    return live_entries();
  endfunction

  function automatic void add_seg(logic [1:0] src, logic [3:0] hit, logic [31:0] start,
                                  logic [31:0] bytes, logic fin);
    seg_t s;
    s.source = src;
    s.entry_hit = hit;
    s.start_offset = start;
    s.segment_bytes = bytes;
    s.last = fin;
    pending_segs.push_back(s);
  endfunction

  // text of one segment for reports
  function automatic string seg_text(seg_t s);
    return $sformatf("src %0d hit %0d start %h bytes %h last %b",
                     s.source, s.entry_hit, s.start_offset, s.segment_bytes, s.last);
  endfunction

  // work out the segments one accepted transfer produces
  function automatic void apply_item(req_t r);
    logic [31:0] off;
    logic [31:0] left;
    logic [31:0] head;
    logic [31:0] endw;
    logic [31:0] piece;
    logic [31:0] skip;
    int unsigned idx;
    int unsigned n;
    if (r.kind == KIND_LOAD) begin
      tbl_start[r.entry_index] = r.entry_start;
      tbl_words[r.entry_index] = r.entry_words;
      return;
    end
    off = r.read_offset;
    left = r.read_bytes & ~32'd3;
    if (left == 0) return;
    // real disc part below the boundary
    if (!off[31]) begin
      endw = off + (left >> 2) - 32'd1;
      if (!endw[31]) begin
        add_seg(SRC_DISC, 4'd0, off, left, 1'b1);
        return;
      end
      head = (SPLIT_WORD - off) << 2;
      left -= head;
      add_seg(SRC_DISC, 4'd0, off, head, left == 0);
      off = SPLIT_WORD;
    end
    // replacement ranges, taken in order from the hit entry
    n = live_entries();
    idx = search_table(off);
    while (left != 0) begin
      if (idx >= n) begin
        add_seg(SRC_ZERO, 4'd0, 32'd0, left, 1'b1);
        return;
      end
      piece = tbl_words[idx] << 2;
      skip = 32'd0;
      if (tbl_start[idx] != off) begin
        skip = (off - tbl_start[idx]) << 2;
        piece -= skip;
      end
      if (piece > left) piece = left;
      left -= piece;
      add_seg(SRC_FILE, 4'(idx), skip, piece, left == 0);
      off += piece >> 2;
      idx++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic req_t random_req();
    req_t r;
    r.kind = 1'($urandom);
    r.entry_index = 4'($urandom);
    r.entry_start = $urandom;
    r.entry_words = $urandom;
    r.read_offset = $urandom;
    r.read_bytes = $urandom;
    return r;
  endfunction

  function automatic void queue_load(logic [3:0] slot, logic [31:0] start, logic [31:0] words);
    req_t r;
    r = random_req();
    r.kind = KIND_LOAD;
    r.entry_index = slot;
    r.entry_start = start;
    r.entry_words = words;
    req_backlog.push_back(r);
    queued_items++;
  endfunction

  function automatic void queue_read(logic [31:0] off, logic [31:0] bytes);
    req_t r;
    r = random_req();
    r.kind = KIND_READ;
    r.read_offset = off;
    r.read_bytes = bytes;
    req_backlog.push_back(r);
    if (bytes >= 4) queued_items++;
  endfunction

  // sorted, contiguous table from base; loads go out in a rotated slot order
  function automatic logic [31:0] queue_table(logic [31:0] base, int unsigned used);
    logic [31:0] starts [TBL_DEPTH];
    logic [31:0] words [TBL_DEPTH];
    logic [31:0] pos;
    logic [31:0] used_end;
    int unsigned first;
    pos = base;
    used_end = base;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      starts[i] = pos;
      words[i] = ($urandom_range(0, 5) == 0) ? 32'd0 : 32'($urandom_range(1, 24));
      pos += words[i];
      if (i < used) used_end = pos;
    end
    first = $urandom_range(0, TBL_DEPTH - 1);
    for (int i = 0; i < TBL_DEPTH; i++)
      queue_load(4'((first + i) % TBL_DEPTH), starts[(first + i) % TBL_DEPTH],
                 words[(first + i) % TBL_DEPTH]);
    return used_end;
  endfunction

  // APB write of entry_count, then a read back of the same register
  task automatic set_entry_count(input logic [4:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_ENTRY_COUNT;
    pwdata <= PDATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    entry_count_sh = v;
    n_settings++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PDATA_W'(v)) begin
      errors++;
      $display("%0t: entry_count read back expected %h, got %h", $time, PDATA_W'(v), prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // hold off the sender until every segment is in, then let the block settle
  task automatic wait_idle();
    while (req_backlog.size() != 0 || req_valid || pending_segs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // request driver: bursts with random gaps
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    logic go;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || in_done) begin
      go = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (req_backlog.size() != 0) begin
        req <= req_backlog.pop_front();
        go = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      req_valid <= go;
    end
  end

  // segment stall pattern: free-running, light or heavy stretches
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(4, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: begin
        seg_stall <= 1'b0;
      end
      1: begin
        seg_stall <= ($urandom_range(0, 2) == 0);
      end
      default: begin
        seg_stall <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on each request transfer, check each segment transfer
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    seg_t want;
    if (rst) begin
      in_done <= 1'b0;
    end else begin
      in_done <= req_valid && !req_stall;
      if (req_valid && !req_stall) begin
        if (req.kind == KIND_LOAD) n_loads++;
        else n_reads++;
        apply_item(req);
      end
      if (seg_valid && !seg_stall) begin
        if (pending_segs.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: segment mismatch, expected none, got %s", $time, seg_text(seg));
        end else begin
          want = pending_segs.pop_front();
          n_segs++;
          if (seg.source !== want.source || seg.entry_hit !== want.entry_hit ||
              seg.start_offset !== want.start_offset ||
              seg.segment_bytes !== want.segment_bytes || seg.last !== want.last) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: segment mismatch, expected %s, got %s",
                       $time, seg_text(want), seg_text(seg));
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    logic [31:0] base;
    logic [31:0] span_end;
    logic [31:0] span;
    logic [4:0] cnt;
    int phase;
    int start_items;
    int pick;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: table at the boundary, slot 3 empty, slot 15 at full length
    set_entry_count(5'd0);
    base = SPLIT_WORD;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      queue_load(4'(i), base, (i == 3) ? 32'd0 : (i == 15) ? 32'hFFFF_FFFF : 32'd16);
      base += (i == 3) ? 32'd0 : 32'd16;
    end
    // empty table: zero length, disc only, up to the boundary, crossing, all zero fill
    queue_read(32'h0000_0000, 32'd3);
    queue_read(32'h0000_0000, 32'hFFFF_FFFC);
    queue_read(32'h7FFF_FFFF, 32'd7);
    queue_read(32'h7FFF_FFF0, 32'h0000_0100);
    queue_read(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_idle();

    // full table: exact hit walking over the empty entry, inside hit, crossing into a hit,
    // walk into the long last entry, miss above the table
    set_entry_count(5'd16);
    queue_read(SPLIT_WORD, 32'h0000_0100);
    queue_read(SPLIT_WORD + 32'd5, 32'd40);
    queue_read(32'h7FFF_FFFC, 32'h0000_0200);
    queue_read(SPLIT_WORD + 32'd20, 32'hFFFF_FFFF);
    queue_read(32'hFFFF_FF00, 32'd64);
    wait_idle();

    // count above the table depth, and an entry behind the offset that wraps the length
    set_entry_count(5'd31);
    queue_load(4'd5, SPLIT_WORD, 32'd1);
    queue_read(SPLIT_WORD + 32'd50, 32'h0000_0100);
    wait_idle();

    // small count: walk runs off the end of the table
    set_entry_count(5'd2);
    queue_read(SPLIT_WORD + 32'd4, 32'h0000_1000);
    wait_idle();

    // random phases: well-formed tables and reads around them, plus noise
    start_items = queued_items;
    phase = 0;
    while (queued_items - start_items < RANDOM_ITEMS) begin
      case (phase % 6)
        0, 3: cnt = 5'd16;
        1, 5: cnt = 5'($urandom_range(2, 15));
        2: cnt = 5'd1;
        default: cnt = 5'd0;
      endcase
      wait_idle();
      set_entry_count(cnt);
      base = SPLIT_WORD + (($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 200)));
      span_end = queue_table(base, (cnt == 0) ? TBL_DEPTH : int'(cnt));
      span = span_end - base;
      for (int j = 0; j < 30; j++) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0: begin
            queue_load(4'($urandom), $urandom, $urandom);
          end
          1: begin
            queue_read($urandom, $urandom);
          end
          2: begin
            queue_read(SPLIT_WORD - 32'($urandom_range(1, 32)), 32'($urandom_range(4, 600)));
          end
          3: begin
            queue_read($urandom & 32'h7FFF_FFFF, 32'($urandom_range(0, 64)));
          end
          default: begin
            queue_read(base - 32'd8 + 32'($urandom_range(0, span + 16)),
                       ($urandom_range(0, 7) == 0) ? $urandom :
                       32'($urandom_range(1, 4 * (span + 16))));
          end
        endcase
      end
      phase++;
    end
    wait_idle();

    $display("%0d loads and %0d reads accepted, %0d segments checked over %0d table settings",
             n_loads, n_reads, n_segs, n_settings);
    $display("covered disc, crossing, hit, walk, empty entry, wrap, miss and exhausted table");
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/prrs_pkg.sv
src/prrs_front.sv
src/prrs_queue.sv
src/prrs_back.sv
src/patched_read_range_splitter_unit.sv
sim/patched_read_range_splitter_unit_tb.sv
